/* src/htb_pkg.sv */
// Shared constants for the Haar temporal band-pass filter.
package htb_pkg;

    localparam int DEFAULT_WINDOW      = 16;
    localparam int DEFAULT_POSITIONS   = 1024;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    localparam int POS_W  = 10;
    localparam int OUT_W  = 21;
    localparam int MASK_W = 4;

    localparam logic [MASK_W-1:0] MASK_RESET = 4'hF;

    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

endpackage

/* src/htb_intf.sv */
// Request and result channel interfaces of the Haar temporal band-pass filter.
interface htb_in_if #(
    parameter int SAMPLE_BITS = htb_pkg::DEFAULT_SAMPLE_BITS
);
    import htb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [POS_W-1:0]              position;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          frame_end;

    modport source (output valid, position, sample, frame_end, input ready);
    modport sink   (input valid, position, sample, frame_end, output ready);
endinterface

interface htb_out_if;
    import htb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;
    logic                    valid_res;

    modport source (output valid, filtered, valid_res, input ready);
    modport sink   (input valid, filtered, valid_res, output ready);
endinterface

/* src/htb_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module htb_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/haar_temporal_bandpass.sv */
// A result is registered once its window pass has drained through the read, product and
// accumulate registers; while the window is still filling, a zero result is registered.
// A new request is taken only after the previous result is registered, paced by the one read port
// of the history memory, which streams the position's WINDOW samples into a multiply-accumulate.
// Reset (synchronous, active low) clears slot, fill count, keep_mask (to all ones) and
// handshakes; the history memory is not cleared and needs no clearing pass.
module haar_temporal_bandpass #(
    parameter int WINDOW      = htb_pkg::DEFAULT_WINDOW,
    parameter int POSITIONS   = htb_pkg::DEFAULT_POSITIONS,
    parameter int SAMPLE_BITS = htb_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [htb_pkg::MASK_W-1:0] i_cfg_wdata,
    htb_in_if.sink                     i_req,
    htb_out_if.source                  o_res
);
    import htb_pkg::*;

    localparam int LEVELS  = $clog2(WINDOW);
    localparam int PIDX_W  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
    localparam int ADDR_W  = PIDX_W + LEVELS;
    localparam int DEPTH   = POSITIONS * WINDOW;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int COEF_W  = LEVELS + 1;
    localparam int PROD_W  = SAMPLE_BITS + COEF_W;
    localparam int ACC_W   = SAMPLE_BITS + LEVELS + $clog2(LEVELS + 1) + 1;
    localparam int EXT_W   = ACC_W + 4;
    localparam int CMP_W   = (EXT_W > OUT_W) ? EXT_W : OUT_W;
    localparam int UP      = (LEVELS <= 4) ? 4 - LEVELS : 0;
    localparam int DN      = (LEVELS > 4) ? LEVELS - 4 : 0;
    localparam int RND     = (1 << DN) >> 1;
    localparam int SH      = POS_W + PIDX_W + 1;
    localparam int QP_W    = POS_W + SH + 1;
    localparam longint RECIP_L = ((longint'(1) << SH) + longint'(POSITIONS) - 1)
                                 / longint'(POSITIONS);
    localparam logic [SH:0]        RECIP = (SH + 1)'(RECIP_L);
    localparam logic [LEVELS-1:0]  LAST  = LEVELS'(WINDOW - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN
    } t_state;

    // Haar synthesis weight of window sample t on the centre output, in units of
    // 2^-LEVELS; bands without a mask bit are always kept.
    function automatic logic signed [COEF_W-1:0] coef_of(
        input logic [MASK_W-1:0] mask,
        input logic [LEVELS-1:0] t
    );
        int          c;
        int          ti;
        int          sum;
        logic [31:0] mext;
        c    = WINDOW / 2;
        ti   = int'(t);
        sum  = 0;
        mext = {{(32 - MASK_W){1'b1}}, mask};
        for (int k = 1; k <= LEVELS; k++) begin
            if (mext[k-1] && ((ti >> k) == (c >> k))) begin
                if (((ti >> (k - 1)) & 1) == ((c >> (k - 1)) & 1)) begin
                    sum = sum + (1 << (LEVELS - k));
                end else begin
                    sum = sum - (1 << (LEVELS - k));
                end
            end
        end
        return COEF_W'(sum);
    endfunction

    t_state                      r_state;
    logic [LEVELS-1:0]           r_slot;
    logic [FILL_W-1:0]           r_filled;
    logic [MASK_W-1:0]           r_keep_mask;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            r_quot;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                        r_win_full;
    logic [LEVELS-1:0]           r_wslot;
    logic [PIDX_W-1:0]           r_idx;
    logic [LEVELS-1:0]           r_t;
    logic                        r_p1_v;
    logic [LEVELS-1:0]           r_p1_t;
    logic                        r_p2_v;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic                        r_out_valid;
    logic signed [OUT_W-1:0]     r_filtered;
    logic                        r_valid_res;

    logic [QP_W-1:0]             w_quot_prod;
    logic [31:0]                 w_rem;
    logic [PIDX_W-1:0]           w_idx;
    logic                        w_we;
    logic [ADDR_W-1:0]           w_waddr;
    logic                        w_rd_en;
    logic [LEVELS-1:0]           w_rd_t;
    logic [PIDX_W-1:0]           w_rd_idx;
    logic [ADDR_W-1:0]           w_raddr;
    logic [SAMPLE_BITS-1:0]      w_rdata;
    logic signed [EXT_W-1:0]     w_ext;
    logic signed [EXT_W-1:0]     w_scaled;
    logic signed [CMP_W-1:0]     w_cmp;
    logic signed [OUT_W-1:0]     w_res;
    logic                        w_drain_go;

    // position modulo POSITIONS: reciprocal quotient at accept, remainder next cycle
    assign w_quot_prod = QP_W'(i_req.position) * QP_W'(RECIP);
    assign w_rem       = 32'(r_pos) - 32'(r_quot) * 32'(POSITIONS);
    assign w_idx       = w_rem[PIDX_W-1:0];

    assign w_we     = (r_state == S_WRITE);
    assign w_waddr  = {w_idx, r_wslot};
    assign w_rd_en  = ((r_state == S_WRITE) && r_win_full) || (r_state == S_READ);
    assign w_rd_t   = (r_state == S_WRITE) ? '0 : r_t;
    assign w_rd_idx = (r_state == S_WRITE) ? w_idx : r_idx;
    // oldest sample sits one slot past the one just written
    assign w_raddr  = {w_rd_idx, r_wslot + LEVELS'(1) + w_rd_t};

    // hold until the accumulator is final and the result register is free
    assign w_drain_go = (r_state == S_DRAIN) && !r_p1_v && !r_p2_v
                        && (!r_out_valid || o_res.ready);

    htb_ram #(
        .WIDTH  (SAMPLE_BITS),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_sample),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // scale to 4 fraction bits, rounding halves up, then saturate
    always_comb begin
        w_ext    = EXT_W'(r_acc);
        w_scaled = ((w_ext <<< UP) + EXT_W'(RND)) >>> DN;
        w_cmp    = CMP_W'(w_scaled);
        if (w_cmp > CMP_W'(OUT_MAX)) begin
            w_res = OUT_W'(OUT_MAX);
        end else if (w_cmp < CMP_W'(OUT_MIN)) begin
            w_res = OUT_W'(OUT_MIN);
        end else begin
            w_res = OUT_W'(w_cmp);
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.filtered  = r_filtered;
    assign o_res.valid_res = r_valid_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_filled    <= '0;
            r_keep_mask <= MASK_RESET;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_keep_mask <= i_cfg_wdata;
            end
            if (o_res.ready && !w_drain_go) begin
                r_out_valid <= 1'b0;
            end

            r_p1_v <= w_rd_en;
            r_p1_t <= w_rd_t;
            r_p2_v <= r_p1_v;
            r_prod <= PROD_W'($signed(w_rdata)) * PROD_W'(coef_of(r_keep_mask, r_p1_t));
            if (r_p2_v) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_pos      <= i_req.position;
                        r_quot     <= w_quot_prod[SH +: POS_W];
                        r_sample   <= i_req.sample;
                        r_win_full <= (r_filled >= FILL_W'(WINDOW - 1));
                        r_wslot    <= r_slot;
                        if (i_req.frame_end) begin
                            r_slot <= r_slot + LEVELS'(1);
                            if (r_filled != FILL_W'(WINDOW)) begin
                                r_filled <= r_filled + FILL_W'(1);
                            end
                        end
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_idx   <= w_idx;
                    r_acc   <= '0;
                    r_t     <= LEVELS'(1);
                    r_state <= r_win_full ? S_READ : S_DRAIN;
                end
                S_READ: begin
                    r_t <= r_t + LEVELS'(1);
                    if (r_t == LAST) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_drain_go) begin
                        r_out_valid <= 1'b1;
                        r_filtered  <= r_win_full ? w_res : '0;
                        r_valid_res <= r_win_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_WRITE))
        else $error("accepted request did not start a history write");

    a_mac_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p2_v |-> (r_state == S_READ || r_state == S_DRAIN))
        else $error("accumulate outside the window pass");

    a_invalid_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.valid_res) |-> (o_res.filtered == '0))
        else $error("result without full window is not zero");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= FILL_W'(WINDOW))
        else $error("fill count beyond window");
`endif

endmodule

/* tb/htb_centre_scoreboard.sv */
// Scoreboard for the Haar temporal band-pass filter: predicts each centre value and checks it.
module htb_centre_scoreboard (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [htb_pkg::MASK_W-1:0] i_cfg_wdata,
    htb_in_if                          req_mon,
    htb_out_if                         res_mon,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import htb_pkg::*;

    localparam int WIN    = DEFAULT_WINDOW;
    localparam int LEVELS = $clog2(WIN);
    localparam int CENTRE = WIN / 2;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    valid_res;
    } t_centre_result;

    logic signed [DEFAULT_SAMPLE_BITS-1:0] sample_hist [DEFAULT_POSITIONS*WIN];
    int                                    cur_slot;
    int                                    frames_seen;
    logic [MASK_W-1:0]                     band_mask;
    t_centre_result                        expected_centres [$];
    t_centre_result                        want;
    int                                    fails;
    int                                    base;

    // Centre of the inverse transform after dropping DC and masked bands, in 1/16 LSB
    function automatic logic signed [OUT_W-1:0] band_centre(input int hbase, input int start);
        longint acc;
        longint sa;
        longint sb;
        longint d;
        int     blk;
        int     hlf;
        int     first;
        acc = 0;
        for (int k = 1; k <= LEVELS; k++) begin
            if (k > MASK_W || band_mask[k-1]) begin
                blk   = 1 << k;
                hlf   = blk >> 1;
                first = (CENTRE >> k) * blk;
                sa    = 0;
                sb    = 0;
                for (int t = 0; t < hlf; t++) begin
                    sa += sample_hist[hbase + (start + first + t) % WIN];
                    sb += sample_hist[hbase + (start + first + hlf + t) % WIN];
                end
                d = (sa - sb) * (longint'(1) << (LEVELS - k));
                if (((CENTRE >> (k - 1)) & 1) != 0) begin
                    acc -= d;
                end else begin
                    acc += d;
                end
            end
        end
        // window of at most 16 frames: scale up to 4 fraction bits, no rounding needed
        acc = acc * (longint'(1) << (4 - LEVELS));
        if (acc > OUT_MAX) begin
            acc = OUT_MAX;
        end
        if (acc < OUT_MIN) begin
            acc = OUT_MIN;
        end
        return acc[OUT_W-1:0];
    endfunction

    initial begin
        fails = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_slot    = 0;
            frames_seen = 0;
            band_mask   = MASK_RESET;
            expected_centres.delete();
        end else begin
            if (res_mon.valid && res_mon.ready) begin
                if (expected_centres.size() == 0) begin
                    $error("unexpected result: filtered %0d, valid_res %0b",
                           res_mon.filtered, res_mon.valid_res);
                    fails++;
                end else begin
                    want = expected_centres.pop_front();
                    if (res_mon.filtered !== want.filtered) begin
                        $error("filtered: expected %0d, actual %0d",
                               want.filtered, res_mon.filtered);
                        fails++;
                    end
                    if (res_mon.valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0b, actual %0b",
                               want.valid_res, res_mon.valid_res);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                band_mask = i_cfg_wdata;
            end
            if (req_mon.valid && req_mon.ready) begin
                base = (int'(req_mon.position) % DEFAULT_POSITIONS) * WIN;
                sample_hist[base + cur_slot] = req_mon.sample;
                want.valid_res = (frames_seen + 1 >= WIN);
                want.filtered  = want.valid_res ? band_centre(base, (cur_slot + 1) % WIN) : '0;
                expected_centres.push_back(want);
                // advance slot and fill count after the frame's last position
                if (req_mon.frame_end) begin
                    cur_slot = (cur_slot + 1) % WIN;
                    if (frames_seen < WIN) begin
                        frames_seen++;
                    end
                end
            end
        end
        o_pending    <= expected_centres.size();
        o_fail_count <= fails;
    end

endmodule

/* tb/tb_haar_temporal_bandpass.sv */
// Top of the Haar temporal band-pass testbench: clock, reset, request stimulus and verdict.
module tb_haar_temporal_bandpass;
    timeunit 1ns;
    timeprecision 1ps;

    import htb_pkg::*;

    localparam int WIN    = DEFAULT_WINDOW;
    localparam int CENTRE = WIN / 2;
    localparam int POOL_N = 6;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MASK_W-1:0] i_cfg_wdata;
    int                fail_count;
    int                pending;

    htb_in_if  req_if ();
    htb_out_if res_if ();

    haar_temporal_bandpass u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    htb_centre_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .req_mon      (req_if),
        .res_mon      (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bit                 bursts_on;
    int                 gap_pct;
    int                 stall_pct;
    int                 slot_ptr;
    int                 frames_done;
    logic [WIN-1:0]     written_slots [DEFAULT_POSITIONS];
    logic [POS_W-1:0]   pool [POOL_N];
    logic [MASK_W-1:0]  phase_masks [6];

    task automatic send_request(input logic [POS_W-1:0] pos,
                                input logic signed [DEFAULT_SAMPLE_BITS-1:0] smp,
                                input logic fe);
        if (bursts_on && $urandom_range(0, 99) < gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.position  <= pos;
        req_if.sample    <= smp;
        req_if.frame_end <= fe;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        written_slots[pos][slot_ptr] = 1'b1;
        if (fe) begin
            slot_ptr = (slot_ptr + 1) % WIN;
            if (frames_done < WIN) begin
                frames_done++;
            end
        end
    endtask

    // Swap a position whose window would still hold unwritten slots for a pool one
    function automatic logic [POS_W-1:0] safe_position(input logic [POS_W-1:0] cand);
        logic [WIN-1:0] after_write;
        after_write = written_slots[cand] | (WIN'(1) << slot_ptr);
        if (frames_done + 1 < WIN || &after_write) begin
            return cand;
        end
        return pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    function automatic logic signed [DEFAULT_SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return '0;
            3:       return DEFAULT_SAMPLE_BITS'($signed($urandom_range(0, 128)) - 64);
            default: return DEFAULT_SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Hold off until every result is back, then write the band mask
    task automatic write_band_mask(input logic [MASK_W-1:0] mask);
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (WIN + 8) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        forever begin
            if (bursts_on && $urandom_range(0, 99) < stall_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        int               rot;
        int               idx;
        logic [POS_W-1:0] pos;
        logic signed [DEFAULT_SAMPLE_BITS-1:0] smp;

        req_if.valid     <= 1'b0;
        req_if.position  <= '0;
        req_if.sample    <= '0;
        req_if.frame_end <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_wdata      <= MASK_RESET;
        i_rst_n          <= 1'b0;
        bursts_on   = 1'b1;
        gap_pct     = 20;
        stall_pct   = 20;
        slot_ptr    = 0;
        frames_done = 0;
        for (int p = 0; p < DEFAULT_POSITIONS; p++) begin
            written_slots[p] = '0;
        end
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = 10'h155;
        pool[3] = 10'h2AA;
        pool[4] = POS_W'($urandom);
        pool[5] = POS_W'($urandom);
        phase_masks[0] = 4'h0;
        phase_masks[1] = 4'h1;
        phase_masks[2] = 4'h2;
        phase_masks[3] = 4'h4;
        phase_masks[4] = 4'h8;
        phase_masks[5] = MASK_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Fill every pool position's history; the centre frame of positions 0 and 1023
        // stands against extreme neighbours to reach the largest and smallest outputs
        for (int f = 0; f < WIN; f++) begin
            rot = $urandom_range(0, POOL_N - 1);
            for (int n = 0; n < POOL_N; n++) begin
                idx = (rot + n) % POOL_N;
                if (idx == 0) begin
                    smp = (f == CENTRE) ? 16'sh7FFF : 16'sh8000;
                end else if (idx == 1) begin
                    smp = (f == CENTRE) ? 16'sh8000 : 16'sh7FFF;
                end else begin
                    smp = random_sample();
                end
                if (f < WIN - 1 && $urandom_range(0, 2) == 0) begin
                    send_request(safe_position(POS_W'($urandom)), random_sample(), 1'b0);
                end
                send_request(pool[idx], smp, n == POOL_N - 1);
            end
        end

        // No band, then one band at a time, then all
        for (int m = 0; m < 6; m++) begin
            write_band_mask(phase_masks[m]);
            send_request(pool[0], 16'sh7FFF, 1'b0);
            send_request(pool[1], 16'sh8000, 1'b0);
        end
        send_request(pool[2], '0, 1'b1);

        for (int ph = 0; ph < 9; ph++) begin
            write_band_mask((ph == 0) ? 4'h0 : (ph == 8) ? MASK_RESET : MASK_W'($urandom));
            bursts_on = (ph != 8);
            gap_pct   = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 10 : 40;
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
            repeat (150) begin
                pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom)
                                                  : pool[$urandom_range(0, POOL_N - 1)];
                send_request(safe_position(pos), random_sample(), $urandom_range(0, 5) == 0);
            end
        end

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (WIN + 10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
